// File: src/video_transition_blender_core_assert.svh
// Assertion macros used by the port-level checker of the transition blender.
`ifndef VIDEO_TRANSITION_BLENDER_CORE_ASSERT_SVH
`define VIDEO_TRANSITION_BLENDER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define VTB_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define VTB_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/vtb_pkg.sv
// Types, constants and codes shared by the transition blender modules.
`default_nettype none

package vtb_pkg;

    // Port widths and stream packing
    localparam int S_TDATA_W   = 104;
    localparam int S_TUSER_W   = 2;
    localparam int M_TDATA_W   = 40;
    localparam int M_TUSER_W   = 1;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 13;
    localparam int PIX_W       = 32;
    localparam int COL_W       = 12;
    localparam int DT_W        = 20;

    // Fixed-point and timing constants
    localparam int                 Q_W          = 17;
    localparam logic [Q_W-1:0]     ONE_Q16      = 17'h10000;
    localparam logic [Q_W-1:0]     HALF_Q16     = 17'h08000;
    localparam int                 ACC_W        = 23;
    localparam logic [ACC_W-1:0]   ELAPSED_MAX  = 23'h7FFFFF;
    localparam logic [CFG_DATA_W-1:0] DUR_MIN_MS = 13'd100;
    localparam logic [CFG_DATA_W-1:0] DUR_MAX_MS = 13'd5000;
    localparam logic [ACC_W-1:0]   US_PER_MS    = 23'd1000;
    localparam logic [ACC_W-1:0]   DUR_US_RESET = 23'd1000000;
    localparam int                 FW_RESET_DEF = 1920;
    localparam int                 VTB_MAX_WIDTH = 4096;

    // Divider: one quotient bit per cycle
    localparam int DIV_STEPS = 16;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    // Item kinds carried on s_tuser
    typedef enum logic [1:0] {
        OP_PIXEL  = 2'd0,
        OP_TICK   = 2'd1,
        OP_BEGIN  = 2'd2,
        OP_CANCEL = 2'd3
    } op_t;

    // Transition modes
    typedef enum logic [2:0] {
        MODE_CUT        = 3'd0,
        MODE_CROSSFADE  = 3'd1,
        MODE_FADE_BLACK = 3'd2,
        MODE_WIPE_LEFT  = 3'd3,
        MODE_WIPE_RIGHT = 3'd4
    } mode_t;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MODE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DURATION = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH    = 2'd2;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_SETTLE
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic take;      // input transaction accepted
        logic div_step;  // run one divider iteration
        logic div_last;  // final iteration: commit progress and tick result
        logic out_pop;   // output transaction taken by the receiver
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic out_full;  // output register holds a result
        logic divides;   // a tick now needs the divider
    } status_t;

endpackage

`default_nettype wire

// File: src/video_transition_blender_core.sv
// Top level of the A/B video transition blender.
// Input stream s_*: one transaction per item; s_tuser carries the kind
// (pixel, tick, begin, cancel), s_tdata the pixel pair, preview flag,
// column and elapsed microseconds. Output stream m_*: one result per pixel
// or tick, none for begin or cancel.
// Pixels: accepted one per cycle unless a stalled result or a write holds
// the input; result registered next cycle. Running non-cut tick: accept,
// 16 divider steps of one quotient bit each, a settle step for the wipe
// split to follow new progress; begin, cancel, other ticks: accept, settle.
// A configuration write holds the input off in its own cycle and the one
// after it, while the wipe split is recomputed; writes have no read-back.
// The output register parts the two sides: while the receiver stalls, one
// result waits and the next item is taken in the cycle the result leaves.
// Reset (synchronous, aresetn low) returns to idle with zero progress,
// crossfade mode, 1000 ms duration and 1920-pixel lines.
`default_nettype none

module video_transition_blender_core
    import vtb_pkg::*;
#(
    parameter int MAX_WIDTH = VTB_MAX_WIDTH
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // [31:0] pixel_a, [63:32] pixel_b, [64] b_present, [76:65] column,
    // [96:77] elapsed_us, [103:97] zero
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    // [1:0] opcode
    input  wire logic [S_TUSER_W-1:0]  s_tuser,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // [31:0] pixel_out, [32] still_running, [39:33] zero
    output logic [M_TDATA_W-1:0]       m_tdata,
    // [0] pixel_ok
    output logic [M_TUSER_W-1:0]       m_tuser,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    cmd_t             cmd;
    status_t          st;
    op_t              opcode;
    logic [PIX_W-1:0] pixel_out;
    logic             pixel_ok;
    logic             still_running;

    assign opcode = op_t'(s_tuser);

    vtb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .opcode   (opcode),
        .m_tready (m_tready),
        .cfg_we   (cfg_we),
        .st       (st),
        .cmd      (cmd)
    );

    vtb_dp #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .st            (st),
        .opcode        (opcode),
        .pixel_a       (s_tdata[31:0]),
        .pixel_b       (s_tdata[63:32]),
        .b_present     (s_tdata[64]),
        .column        (s_tdata[76:65]),
        .elapsed_us    (s_tdata[96:77]),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .out_valid     (m_tvalid),
        .pixel_out     (pixel_out),
        .pixel_ok      (pixel_ok),
        .still_running (still_running)
    );

    // Pack the result transaction
    assign m_tdata = {7'b0, still_running, pixel_out};
    assign m_tuser = pixel_ok;

endmodule

`default_nettype wire

// File: src/vtb_ctrl.sv
// Controller state machine of the transition blender.
`default_nettype none

module vtb_ctrl
    import vtb_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_tvalid,
    output logic         s_tready,
    input  wire op_t     opcode,
    input  wire logic    m_tready,
    input  wire logic    cfg_we,
    input  wire status_t st,
    output cmd_t         cmd
);

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    // State and step counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Next state and commands
    always_comb begin
        s_tready     = (state_reg == S_IDLE) && (!st.out_full || m_tready) && !cfg_we;
        cmd.take     = s_tvalid && s_tready;
        cmd.div_step = (state_reg == S_DIV);
        cmd.div_last = (state_reg == S_DIV) && (cnt_reg == CNT_LAST);
        cmd.out_pop  = st.out_full && m_tready;
        state_next   = state_reg;
        cnt_next     = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (cmd.take) begin
                    if (opcode == OP_PIXEL) begin
                        state_next = S_IDLE;
                    end else if (opcode == OP_TICK && st.divides) begin
                        state_next = S_DIV;
                    end else begin
                        state_next = S_SETTLE;
                    end
                end else if (cfg_we) begin
                    state_next = S_SETTLE;
                end
            end
            S_DIV: begin
                cnt_next = cnt_reg + 1'b1;
                if (cmd.div_last) begin
                    state_next = S_SETTLE;
                    cnt_next   = '0;
                end
            end
            S_SETTLE: begin
                // hold here while configuration keeps changing
                if (!cfg_we) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: src/vtb_dp.sv
// Datapath of the transition blender: registers, divider, mixer, output stage.
`default_nettype none

module vtb_dp
    import vtb_pkg::*;
#(
    parameter int MAX_WIDTH = VTB_MAX_WIDTH
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire cmd_t                  cmd,
    output status_t                    st,
    input  wire op_t                   opcode,
    input  wire logic [PIX_W-1:0]      pixel_a,
    input  wire logic [PIX_W-1:0]      pixel_b,
    input  wire logic                  b_present,
    input  wire logic [COL_W-1:0]      column,
    input  wire logic [DT_W-1:0]       elapsed_us,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    output logic                       out_valid,
    output logic [PIX_W-1:0]           pixel_out,
    output logic                       pixel_ok,
    output logic                       still_running
);

    localparam int FW_W = $clog2(MAX_WIDTH + 1);
    localparam int PW   = Q_W + FW_W;
    localparam int CW   = (FW_W > COL_W) ? FW_W : COL_W;
    localparam int FW_RST_I = (FW_RESET_DEF > MAX_WIDTH) ? MAX_WIDTH : FW_RESET_DEF;
    localparam logic [FW_W-1:0]       FW_RST  = FW_W'(FW_RST_I);
    localparam logic [CFG_DATA_W:0]   FW_MAXC = (CFG_DATA_W + 1)'(MAX_WIDTH);

    // Configuration
    mode_t             mode_reg, mode_next;
    logic [ACC_W-1:0]  dur_us_reg, dur_us_next;
    logic [FW_W-1:0]   fw_reg, fw_next;

    // Transition state
    logic              active_reg, active_next;
    logic [Q_W-1:0]    progress_reg, progress_next;
    logic [ACC_W-1:0]  elapsed_reg, elapsed_next;

    // Divider
    logic [ACC_W-1:0]  rem_reg, rem_next;
    logic [15:0]       quot_reg, quot_next;
    logic              sat_reg, sat_next;

    // Wipe split
    logic [FW_W-1:0]   split_reg;
    logic [PW-1:0]     split_prod;

    // Output stage
    logic              out_valid_reg, out_valid_next;
    logic [PIX_W-1:0]  out_pix_reg, out_pix_next;
    logic              out_ok_reg, out_ok_next;
    logic              out_run_reg, out_run_next;

    // Combinational helpers
    logic [CFG_DATA_W-1:0] dur_ms;
    logic [CFG_DATA_W:0]   fw_clamp;
    logic [ACC_W:0]        sum_raw;
    logic [ACC_W-1:0]      sum_sat;
    logic                  sat_now;
    logic [ACC_W:0]        rem_dbl;
    logic [ACC_W:0]        rem_diff;
    logic                  q_bit;
    logic [15:0]           q_final;
    logic [PIX_W-1:0]      mix_pix;
    logic                  mix_ok;

    assign st.out_full = out_valid_reg;
    assign st.divides  = active_reg && (mode_reg != MODE_CUT);

    assign out_valid     = out_valid_reg;
    assign pixel_out     = out_pix_reg;
    assign pixel_ok      = out_ok_reg;
    assign still_running = out_run_reg;

    // Register split column from the current progress
    assign split_prod = PW'(progress_reg) * PW'(fw_reg);

    // Configuration writes, clamped as they arrive
    always_comb begin
        mode_next   = mode_reg;
        dur_us_next = dur_us_reg;
        fw_next     = fw_reg;
        dur_ms      = cfg_wdata;
        if (cfg_wdata < DUR_MIN_MS) begin
            dur_ms = DUR_MIN_MS;
        end else if (cfg_wdata > DUR_MAX_MS) begin
            dur_ms = DUR_MAX_MS;
        end
        fw_clamp = {1'b0, cfg_wdata};
        if (cfg_wdata == '0) begin
            fw_clamp = (CFG_DATA_W + 1)'(1);
        end else if ({1'b0, cfg_wdata} > FW_MAXC) begin
            fw_clamp = FW_MAXC;
        end
        if (cfg_we) begin
            unique case (cfg_index)
                CFG_MODE: begin
                    if (cfg_wdata[2:0] <= MODE_WIPE_RIGHT) begin
                        mode_next = mode_t'(cfg_wdata[2:0]);
                    end
                end
                CFG_DURATION: begin
                    dur_us_next = ACC_W'(dur_ms) * US_PER_MS;
                end
                CFG_WIDTH: begin
                    fw_next = FW_W'(fw_clamp);
                end
                default: begin
                    // unknown index: drop the write
                end
            endcase
        end
    end

    // Tick accumulation and restoring division step
    always_comb begin
        sum_raw  = {1'b0, elapsed_reg} + (ACC_W + 1)'(elapsed_us);
        sum_sat  = sum_raw[ACC_W] ? ELAPSED_MAX : sum_raw[ACC_W-1:0];
        sat_now  = (sum_sat >= dur_us_reg);
        rem_dbl  = {rem_reg, 1'b0};
        rem_diff = rem_dbl - {1'b0, dur_us_reg};
        q_bit    = (rem_dbl >= {1'b0, dur_us_reg});
        q_final  = {quot_reg[14:0], q_bit};
    end

    // Pixel mixer
    always_comb begin
        logic [PIX_W-1:0] b_sel;
        logic [PIX_W-1:0] fade_src;
        logic [PIX_W-1:0] xfade;
        logic [PIX_W-1:0] fade;
        logic [Q_W-1:0]   inv;
        logic [Q_W:0]     t2;
        logic [Q_W-1:0]   gain;
        logic [24:0]      acc;
        logic [CW-1:0]    col_x;
        logic [CW-1:0]    split_x;
        logic [CW-1:0]    thr_x;
        b_sel    = b_present ? pixel_b : pixel_a;
        inv      = ONE_Q16 - progress_reg;
        t2       = {progress_reg, 1'b0};
        if (progress_reg < HALF_Q16) begin
            fade_src = pixel_a;
            gain     = Q_W'({1'b0, ONE_Q16} - t2);
        end else begin
            fade_src = b_sel;
            gain     = Q_W'(t2 - {1'b0, ONE_Q16});
        end
        xfade = '0;
        fade  = {8'hFF, 24'h0};
        for (int k = 0; k < 4; k++) begin
            acc = 25'(pixel_a[8*k +: 8]) * 25'(inv) + 25'(b_sel[8*k +: 8]) * 25'(progress_reg);
            xfade[8*k +: 8] = acc[23:16];
        end
        for (int k = 0; k < 3; k++) begin
            acc = 25'(fade_src[8*k +: 8]) * 25'(gain);
            fade[8*k +: 8] = acc[23:16];
        end
        col_x   = CW'(column);
        split_x = CW'(split_reg);
        thr_x   = CW'(fw_reg - split_reg);

        mix_ok = 1'b1;
        if (!active_reg) begin
            // before a transition A passes, after it B passes if present
            if (progress_reg < ONE_Q16) begin
                mix_pix = pixel_a;
            end else if (b_present) begin
                mix_pix = pixel_b;
            end else begin
                mix_pix = '0;
                mix_ok  = 1'b0;
            end
        end else begin
            case (mode_reg)
                MODE_CUT:        mix_pix = b_sel;
                MODE_CROSSFADE:  mix_pix = xfade;
                MODE_FADE_BLACK: mix_pix = fade;
                MODE_WIPE_LEFT:  mix_pix = (col_x < split_x) ? b_sel : pixel_a;
                default:         mix_pix = (col_x >= thr_x) ? b_sel : pixel_a;
            endcase
        end
    end

    // Item handling, divider commit and output stage
    always_comb begin
        active_next    = active_reg;
        progress_next  = progress_reg;
        elapsed_next   = elapsed_reg;
        rem_next       = rem_reg;
        quot_next      = quot_reg;
        sat_next       = sat_reg;
        out_valid_next = out_valid_reg;
        out_pix_next   = out_pix_reg;
        out_ok_next    = out_ok_reg;
        out_run_next   = out_run_reg;

        // drop the result once taken
        if (cmd.out_pop) begin
            out_valid_next = 1'b0;
        end

        if (cmd.take) begin
            unique case (opcode)
                OP_PIXEL: begin
                    out_valid_next = 1'b1;
                    out_pix_next   = mix_pix;
                    out_ok_next    = mix_ok;
                    out_run_next   = 1'b0;
                end
                OP_TICK: begin
                    if (st.divides) begin
                        elapsed_next = sum_sat;
                        rem_next     = sum_sat;
                        sat_next     = sat_now;
                    end else begin
                        // a cut finishes on its first tick
                        if (active_reg) begin
                            progress_next = ONE_Q16;
                            active_next   = 1'b0;
                        end
                        out_valid_next = 1'b1;
                        out_pix_next   = '0;
                        out_ok_next    = 1'b0;
                        out_run_next   = 1'b0;
                    end
                end
                OP_BEGIN: begin
                    active_next   = 1'b1;
                    progress_next = '0;
                    elapsed_next  = '0;
                end
                OP_CANCEL: begin
                    active_next   = 1'b0;
                    progress_next = '0;
                    elapsed_next  = '0;
                end
                default: begin
                end
            endcase
        end

        // advance the divider one quotient bit
        if (cmd.div_step) begin
            rem_next  = q_bit ? rem_diff[ACC_W-1:0] : rem_dbl[ACC_W-1:0];
            quot_next = q_final;
        end

        // commit the new progress and report the tick
        if (cmd.div_last) begin
            progress_next  = sat_reg ? ONE_Q16 : {1'b0, q_final};
            active_next    = !sat_reg;
            out_valid_next = 1'b1;
            out_pix_next   = '0;
            out_ok_next    = 1'b0;
            out_run_next   = !sat_reg;
        end
    end

    // Control and configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= MODE_CROSSFADE;
            dur_us_reg    <= DUR_US_RESET;
            fw_reg        <= FW_RST;
            active_reg    <= 1'b0;
            progress_reg  <= '0;
            elapsed_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            mode_reg      <= mode_next;
            dur_us_reg    <= dur_us_next;
            fw_reg        <= fw_next;
            active_reg    <= active_next;
            progress_reg  <= progress_next;
            elapsed_reg   <= elapsed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        rem_reg     <= rem_next;
        quot_reg    <= quot_next;
        sat_reg     <= sat_next;
        split_reg   <= split_prod[FW_W+15:16];
        out_pix_reg <= out_pix_next;
        out_ok_reg  <= out_ok_next;
        out_run_reg <= out_run_next;
    end

endmodule

`default_nettype wire

// File: src/vtb_checker.sv
// Port-level checker for the transition blender, bound to the top level.
`default_nettype none
`include "video_transition_blender_core_assert.svh"

module vtb_checker
    import vtb_pkg::*;
(
    input wire logic                  aclk,
    input wire logic                  aresetn,
    input wire logic [S_TUSER_W-1:0]  s_tuser,
    input wire logic                  s_tvalid,
    input wire logic                  s_tready,
    input wire logic [M_TDATA_W-1:0]  m_tdata,
    input wire logic [M_TUSER_W-1:0]  m_tuser,
    input wire logic                  m_tvalid,
    input wire logic                  m_tready,
    input wire logic                  cfg_we
);

    // A stalled result holds
    `VTB_ASSERT_NXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

    // A running tick result never claims a valid pixel
    `VTB_ASSERT_IMP(a_tick_no_pixel, aclk, aresetn, m_tvalid && m_tdata[32], !m_tuser[0] && (m_tdata[31:0] == '0), "tick result carries pixel data")

    // Input stays blocked in the cycle after a configuration write
    `VTB_ASSERT_NXT(a_cfg_settle, aclk, aresetn, cfg_we, !s_tready, "input ready right after a configuration write")

    // Any non-pixel transaction blocks the input in the next cycle
    `VTB_ASSERT_NXT(a_ctl_settle, aclk, aresetn, s_tvalid && s_tready && (s_tuser != OP_PIXEL), !s_tready, "input ready right after a control transaction")

endmodule

bind video_transition_blender_core vtb_checker u_vtb_checker (.*);

`default_nettype wire

// File: tb/vtb_result_checker.sv
// Scoreboard for the transition blender: predicts each result and checks the output stream.
`timescale 1ns / 100ps

module vtb_result_checker
    import vtb_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    input  wire logic [S_TUSER_W-1:0]  s_tuser,
    input  wire logic                  s_tvalid,
    input  wire logic                  s_tready,
    input  wire logic [M_TDATA_W-1:0]  m_tdata,
    input  wire logic [M_TUSER_W-1:0]  m_tuser,
    input  wire logic                  m_tvalid,
    input  wire logic                  m_tready,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    output int                         errors,
    output int                         pending
);

    typedef longint unsigned u64_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             ok;
        logic             running;
    } blend_out_t;

    // Results still owed by the block, oldest first
    blend_out_t blend_q[$];

    // Shadow copy of the registers
    mode_t                 mix_mode;
    logic [CFG_DATA_W-1:0] dur_ms;
    logic [CFG_DATA_W-1:0] line_width;

    // Shadow copy of the transition state
    logic                  in_transition;
    logic [Q_W-1:0]        pos_q16;
    logic [ACC_W-1:0]      elapsed_us;

    function automatic logic [PIX_W-1:0] crossfade_mix(logic [PIX_W-1:0] a, logic [PIX_W-1:0] b,
                                                       logic [Q_W-1:0] t);
        logic [PIX_W-1:0] px;
        u64_t             acc;
        int               k;
        px = '0;
        for (k = 0; k < 4; k++) begin
            acc = u64_t'(a[8*k +: 8]) * (u64_t'(ONE_Q16) - u64_t'(t))
                + u64_t'(b[8*k +: 8]) * u64_t'(t);
            px[8*k +: 8] = acc[23:16];
        end
        return px;
    endfunction

    function automatic logic [PIX_W-1:0] fade_black_mix(logic [PIX_W-1:0] a, logic [PIX_W-1:0] b,
                                                        logic [Q_W-1:0] t);
        logic [PIX_W-1:0] src;
        logic [PIX_W-1:0] px;
        u64_t             gain;
        u64_t             acc;
        int               k;
        // First half darkens A, second half brings up B
        if (t < HALF_Q16) begin
            src  = a;
            gain = u64_t'(ONE_Q16) - 2 * u64_t'(t);
        end else begin
            src  = b;
            gain = 2 * (u64_t'(t) - u64_t'(HALF_Q16));
        end
        px = 32'hFF00_0000;
        for (k = 0; k < 3; k++) begin
            acc = u64_t'(src[8*k +: 8]) * gain;
            px[8*k +: 8] = acc[23:16];
        end
        return px;
    endfunction

    function automatic logic [PIX_W-1:0] wipe_mix(logic [PIX_W-1:0] a, logic [PIX_W-1:0] b,
                                                  logic [Q_W-1:0] t, logic [COL_W-1:0] col,
                                                  logic to_left);
        u64_t split;
        split = (u64_t'(t) * u64_t'(line_width)) >> 16;
        if (to_left)
            return (u64_t'(col) < split) ? b : a;
        return (u64_t'(col) >= u64_t'(line_width) - split) ? b : a;
    endfunction

    // Advance the shadow state by one item and queue the result it causes
    function automatic void track_item(op_t op, logic [PIX_W-1:0] pa, logic [PIX_W-1:0] pb,
                                       logic bp, logic [COL_W-1:0] col, logic [DT_W-1:0] dt);
        blend_out_t       r;
        logic [PIX_W-1:0] b_src;
        u64_t             sum;
        u64_t             quo;
        r = '0;
        case (op)
            OP_BEGIN, OP_CANCEL: begin
                in_transition = (op == OP_BEGIN);
                pos_q16       = '0;
                elapsed_us    = '0;
            end
            OP_TICK: begin
                if (in_transition) begin
                    if (mix_mode == MODE_CUT) begin
                        pos_q16       = ONE_Q16;
                        in_transition = 1'b0;
                    end else begin
                        sum = u64_t'(elapsed_us) + u64_t'(dt);
                        if (sum > u64_t'(ELAPSED_MAX))
                            sum = u64_t'(ELAPSED_MAX);
                        elapsed_us = sum[ACC_W-1:0];
                        quo = (sum << 16) / (u64_t'(dur_ms) * 1000);
                        if (quo >= u64_t'(ONE_Q16)) begin
                            pos_q16       = ONE_Q16;
                            in_transition = 1'b0;
                        end else begin
                            pos_q16   = quo[Q_W-1:0];
                            r.running = 1'b1;
                        end
                    end
                end
                blend_q.push_back(r);
            end
            default: begin
                r.ok = 1'b1;
                if (!in_transition) begin
                    if (pos_q16 < ONE_Q16)
                        r.pixel = pa;
                    else if (bp)
                        r.pixel = pb;
                    else
                        r.ok = 1'b0;
                end else begin
                    // Without a preview frame, A stands in for B
                    b_src = bp ? pb : pa;
                    case (mix_mode)
                        MODE_CUT:        r.pixel = b_src;
                        MODE_CROSSFADE:  r.pixel = crossfade_mix(pa, b_src, pos_q16);
                        MODE_FADE_BLACK: r.pixel = fade_black_mix(pa, b_src, pos_q16);
                        MODE_WIPE_LEFT:  r.pixel = wipe_mix(pa, b_src, pos_q16, col, 1'b1);
                        default:         r.pixel = wipe_mix(pa, b_src, pos_q16, col, 1'b0);
                    endcase
                end
                blend_q.push_back(r);
            end
        endcase
    endfunction

    // Apply a register write, with the block's clamping
    function automatic void track_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        case (idx)
            CFG_MODE: begin
                if (val[2:0] <= MODE_WIPE_RIGHT)
                    mix_mode = mode_t'(val[2:0]);
            end
            CFG_DURATION: begin
                dur_ms = (val < DUR_MIN_MS) ? DUR_MIN_MS : (val > DUR_MAX_MS) ? DUR_MAX_MS : val;
            end
            CFG_WIDTH: begin
                if (val == '0)
                    line_width = 13'd1;
                else if (val > VTB_MAX_WIDTH)
                    line_width = CFG_DATA_W'(VTB_MAX_WIDTH);
                else
                    line_width = val;
            end
            default: ;
        endcase
    endfunction

    // Compare the output first: a result never leaves in the cycle its item enters
    always @(posedge aclk) begin
        blend_out_t want;
        if (!aresetn) begin
            mix_mode      = MODE_CROSSFADE;
            dur_ms        = 13'd1000;
            line_width    = CFG_DATA_W'(FW_RESET_DEF);
            in_transition = 1'b0;
            pos_q16       = '0;
            elapsed_us    = '0;
            blend_q.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (blend_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result, expected none, actual %h / %b",
                             $time, m_tdata, m_tuser);
                end else begin
                    want = blend_q.pop_front();
                    if (m_tdata[PIX_W-1:0] !== want.pixel) begin
                        errors++;
                        $display("%0t: pixel_out expected %h actual %h",
                                 $time, want.pixel, m_tdata[PIX_W-1:0]);
                    end
                    if (m_tuser[0] !== want.ok) begin
                        errors++;
                        $display("%0t: pixel_ok expected %b actual %b",
                                 $time, want.ok, m_tuser[0]);
                    end
                    if (m_tdata[PIX_W] !== want.running) begin
                        errors++;
                        $display("%0t: still_running expected %b actual %b",
                                 $time, want.running, m_tdata[PIX_W]);
                    end
                end
            end
            if (s_tvalid && s_tready)
                track_item(op_t'(s_tuser), s_tdata[31:0], s_tdata[63:32], s_tdata[64],
                           s_tdata[76:65], s_tdata[96:77]);
            if (cfg_we)
                track_write(cfg_index, cfg_wdata);
        end
        pending <= blend_q.size();
    end

endmodule

// File: tb/tb_video_transition_blender_core.sv
// Testbench top for the transition blender: clock, reset, stimulus and the verdict.
`timescale 1ns / 100ps

module tb_video_transition_blender_core;
    import vtb_pkg::*;

    localparam int CLK_PERIOD    = 8;
    localparam int RESET_CYCLES  = 10;
    localparam int RANDOM_ITEMS  = 1100;
    localparam int SETTLE_CYCLES = 24;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int MAX_GAP       = 10;

    // Index with no register behind it
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    logic                  aclk;
    logic                  aresetn;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic [S_TUSER_W-1:0]  s_tuser;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [M_TUSER_W-1:0]  m_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    int                    errors;
    int                    pending;
    int unsigned           cycle_cnt;
    int unsigned           sent;
    logic                  rush;
    // Clamped values last written, used to scale ticks and columns
    int unsigned           line_px;
    int unsigned           dur_ms;

    video_transition_blender_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    vtb_result_checker u_scoreboard (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .errors    (errors),
        .pending   (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    // Count cycles and abort a hung run
    always @(posedge aclk) cycle_cnt <= cycle_cnt + 1;

    initial begin
        wait (cycle_cnt >= CYCLE_LIMIT);
        $display("tb_video_transition_blender_core: FAIL");
        $finish;
    end

    function automatic int unsigned draw_gap();
        return rush ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    function automatic logic [PIX_W-1:0] rand_px();
        case ($urandom_range(0, 7))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [COL_W-1:0] rand_col();
        if ($urandom_range(0, 1))
            return COL_W'($urandom_range(0, 4095));
        return COL_W'($urandom_range(0, line_px - 1));
    endfunction

    // Present one transaction after a random gap and hold it until accepted
    task automatic send_item(op_t op, logic [PIX_W-1:0] pa, logic [PIX_W-1:0] pb, logic bp,
                             logic [COL_W-1:0] col, logic [DT_W-1:0] dt);
        int unsigned gap;
        gap = draw_gap();
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid = 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tuser  = op;
        s_tdata  = {7'b0, dt, col, bp, pb, pa};
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        sent++;
    endtask

    task automatic send_pixel();
        send_item(OP_PIXEL, rand_px(), rand_px(), $urandom_range(0, 3) != 0, rand_col(),
                  DT_W'($urandom()));
    endtask

    task automatic send_tick(logic [DT_W-1:0] dt);
        send_item(OP_TICK, $urandom(), $urandom(), 1'($urandom()), COL_W'($urandom()), dt);
    endtask

    task automatic send_event(op_t op);
        send_item(op, $urandom(), $urandom(), 1'($urandom()), COL_W'($urandom()),
                  DT_W'($urandom()));
    endtask

    task automatic send_any();
        case ($urandom_range(0, 3))
            0:       send_pixel();
            1:       send_tick(DT_W'($urandom()));
            2:       send_event(OP_BEGIN);
            default: send_event(OP_CANCEL);
        endcase
    endtask

    // Stop sending, wait for every owed result, then let a long tick finish
    task automatic drain();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pending != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_wdata = val;
        @(negedge aclk);
        cfg_we    = 1'b0;
        case (idx)
            CFG_DURATION: dur_ms  = (val < 100) ? 100 : (val > 5000) ? 5000 : val;
            CFG_WIDTH:    line_px = (val == 0) ? 1 : (val > VTB_MAX_WIDTH) ? VTB_MAX_WIDTH : val;
            default: ;
        endcase
    endtask

    task automatic pick_settings();
        if ($urandom_range(0, 3) != 0)
            write_reg(CFG_MODE, ($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom())
                                                            : CFG_DATA_W'($urandom_range(0, 4)));
        if ($urandom_range(0, 1)) begin
            case ($urandom_range(0, 5))
                0:       write_reg(CFG_DURATION, 13'd0);
                1:       write_reg(CFG_DURATION, DUR_MIN_MS);
                2:       write_reg(CFG_DURATION, DUR_MAX_MS);
                3:       write_reg(CFG_DURATION, 13'h1FFF);
                4:       write_reg(CFG_DURATION, CFG_DATA_W'($urandom()));
                default: write_reg(CFG_DURATION, CFG_DATA_W'($urandom_range(100, 1000)));
            endcase
        end
        if ($urandom_range(0, 1)) begin
            case ($urandom_range(0, 5))
                0:       write_reg(CFG_WIDTH, 13'd0);
                1:       write_reg(CFG_WIDTH, 13'd1);
                2:       write_reg(CFG_WIDTH, 13'd4096);
                3:       write_reg(CFG_WIDTH, 13'h1FFF);
                4:       write_reg(CFG_WIDTH, CFG_DATA_W'($urandom()));
                default: write_reg(CFG_WIDTH, CFG_DATA_W'($urandom_range(1, 64)));
            endcase
        end
        if ($urandom_range(0, 7) == 0)
            write_reg(CFG_SPARE, CFG_DATA_W'($urandom()));
    endtask

    // One transition: settings, begin, pixels between ticks, then pixels after the end
    task automatic run_episode();
        int unsigned steps;
        int unsigned dt_top;
        int unsigned i;
        drain();
        rush = ($urandom_range(0, 3) == 0);
        pick_settings();
        repeat ($urandom_range(0, 2)) send_any();
        send_event(OP_BEGIN);
        dt_top = (dur_ms * 1000) / $urandom_range(2, 16);
        if (dt_top > 20'hFFFFF)
            dt_top = 20'hFFFFF;
        steps = $urandom_range(2, 10);
        for (i = 0; i < steps; i++) begin
            repeat ($urandom_range(0, 5)) send_pixel();
            case ($urandom_range(0, 15))
                0:       send_event(OP_CANCEL);
                1:       send_event(OP_BEGIN);
                2:       send_tick(DT_W'($urandom()));
                3:       send_any();
                default: send_tick(DT_W'($urandom_range(0, dt_top)));
            endcase
        end
        if ($urandom_range(0, 1))
            send_tick(20'hFFFFF);
        repeat ($urandom_range(0, 4)) send_pixel();
    endtask

    // Receiver: stall a random number of cycles before each result
    initial begin : result_sink
        int unsigned stall;
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            stall = draw_gap();
            if (stall > 0) begin
                @(negedge aclk);
                m_tready = 1'b0;
                repeat (stall - 1) @(negedge aclk);
            end
            @(negedge aclk);
            m_tready = 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = OP_PIXEL;
        cfg_we    = 1'b0;
        cfg_index = CFG_MODE;
        cfg_wdata = '0;
        rush      = 1'b0;
        line_px   = FW_RESET_DEF;
        dur_ms    = 1000;
        sent      = 0;
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Idle: A passes, a tick reports not running, cancel does nothing
        send_item(OP_PIXEL, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 12'd0, 20'd0);
        send_tick(20'd0);
        send_event(OP_CANCEL);
        // Crossfade at its start, half way, and with the preview missing
        send_event(OP_BEGIN);
        send_item(OP_PIXEL, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 12'd0, 20'd0);
        send_tick(20'd500000);
        send_item(OP_PIXEL, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 12'd4095, 20'hFFFFF);
        send_item(OP_PIXEL, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 12'd4095, 20'hFFFFF);
        // Restart while running, overrun the duration, then done with and without preview
        send_event(OP_BEGIN);
        send_tick(20'hFFFFF);
        send_item(OP_PIXEL, 32'h1234_5678, 32'h9ABC_DEF0, 1'b1, 12'd7, 20'd0);
        send_item(OP_PIXEL, 32'h1234_5678, 32'h9ABC_DEF0, 1'b0, 12'd7, 20'd0);
        send_event(OP_CANCEL);
        send_item(OP_PIXEL, 32'h0F0F_0F0F, 32'hF0F0_F0F0, 1'b1, 12'd0, 20'd0);

        // Fade through black, shortest duration, narrowest line; ignored writes in between
        drain();
        write_reg(CFG_MODE, CFG_DATA_W'(MODE_FADE_BLACK));
        write_reg(CFG_MODE, 13'd7);
        write_reg(CFG_SPARE, 13'h1FFF);
        write_reg(CFG_DURATION, 13'd0);
        write_reg(CFG_WIDTH, 13'd0);
        send_event(OP_BEGIN);
        send_tick(20'd50000);
        send_item(OP_PIXEL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 12'd0, 20'd0);
        send_tick(20'd25000);
        send_item(OP_PIXEL, 32'h80FF_4020, 32'h00C0_A0FF, 1'b0, 12'd1, 20'd0);

        // Cut, longest duration, widest line
        drain();
        write_reg(CFG_MODE, CFG_DATA_W'(MODE_CUT));
        write_reg(CFG_DURATION, 13'h1FFF);
        write_reg(CFG_WIDTH, 13'h1FFF);
        send_event(OP_BEGIN);
        send_pixel();
        send_tick(20'd1);
        send_pixel();

        // Random transitions
        sent = 0;
        while (sent < RANDOM_ITEMS)
            run_episode();

        drain();
        if (errors == 0 && pending == 0)
            $display("tb_video_transition_blender_core: PASS");
        else
            $display("tb_video_transition_blender_core: FAIL");
        $finish;
    end

endmodule
